@@ hdl/first_fit_block_allocator_top_macros.svh @@
// assertion macros for the first-fit allocator
// used by first_fit_block_allocator_top; no dependencies
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define FFA_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define FFA_ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

@@ hdl/ffa_pkg.sv @@
// package for the first-fit allocator: status codes and beat types
// no dependencies
package ffa_pkg;
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_NULL = 2'd2;
  localparam logic [1:0] ST_BADADDR = 2'd3;
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE = 1'b1;
  localparam int MIN_SPLIT_SPARE = 8;

  typedef struct packed {
    logic       kind;
    logic [9:0] request_size;
    logic [9:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] granted_address;
    logic [9:0] used_bytes;
    logic [9:0] free_bytes;
  } rsp_t;
endpackage

@@ hdl/ffa_if.sv @@
// valid/ready channel interfaces for request and response beats
// depends on ffa_pkg
interface ffa_req_if;
  logic valid;
  logic ready;
  ffa_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ffa_rsp_if;
  logic valid;
  logic ready;
  ffa_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/first_fit_block_allocator_top.sv @@
// First-fit heap allocator with coalescing. The block table lives in a
// synchronous memory of MAX_BLOCKS entries with one read and one write port;
// each request walks it one entry at a time (issue the read, then use the
// data). An allocate scans to the fitting block, a split then shifts the tail
// up one entry at a time, and a free scans for the offset and then runs a
// compacting merge pass over the whole table. A final pass sums used and free
// bytes. Requests are handled one at a time. A new request is taken only
// after the previous response beat has been accepted. Reset needs no clearing
// pass.
// depends on ffa_pkg, ffa_if and first_fit_block_allocator_top_macros.svh
`include "first_fit_block_allocator_top_macros.svh"
module first_fit_block_allocator_top #(
  parameter int HEAP_BYTES = 1024,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_BLOCKS = 64
) (
  input logic clk,
  input logic rst,
  ffa_req_if.sink req,
  ffa_rsp_if.source rsp
);
  import ffa_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int DW = $clog2(HEAP_BYTES + 1);
  localparam int SW = DW + 2;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_SHIFT = 4'd2;
  localparam logic [3:0] S_SPLIT = 4'd3;
  localparam logic [3:0] S_MERGE = 4'd4;
  localparam logic [3:0] S_SUM = 4'd5;
  localparam logic [3:0] S_DONE = 4'd6;
  localparam logic [3:0] S_RD = 4'd7;

  // table memory: payload and free mark, one read and one write per cycle
  logic [DW:0] mem [MAX_BLOCKS];
  logic [DW:0] rdata;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [DW:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [3:0] state;
  logic [CW-1:0] count, idx, kept;
  logic [SW-1:0] offset;
  logic [SW-1:0] used, freeb;
  req_t cur;
  logic [1:0] status;
  logic [9:0] granted;
  logic [AW-1:0] hit;
  logic [DW-1:0] acc;
  logic acc_free, have_acc;
  logic [3:0] back;
  logic [DW-1:0] split_rest;
  logic rsp_valid;
  rsp_t rsp_data;
  logic phase;

  logic [DW-1:0] r_pay;
  logic r_free;
  assign r_pay = rdata[DW-1:0];
  assign r_free = rdata[DW];

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data = rsp_data;

  // sequencer: S_RD issues a read, the working state consumes it next cycle
  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
    if (rst) begin
      state <= S_DONE;
      back <= S_IDLE;
      phase <= 1'b1;
      count <= CW'(1);
      rsp_valid <= 1'b0;
      we <= 1'b1;
      waddr <= '0;
      wdata <= {1'b1, DW'(HEAP_BYTES - HEADER_BYTES)};
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur <= req.data;
            idx <= '0;
            offset <= '0;
            granted <= '0;
            status <= ST_DONE;
            if (req.data.kind == KIND_FREE && req.data.address == '0) begin
              status <= ST_NULL;
              back <= S_SUM;
            end else begin
              back <= S_SCAN;
            end
            raddr <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= back;
          if (back == S_SUM) begin
            used <= '0;
            freeb <= '0;
            idx <= '0;
            raddr <= '0;
            state <= S_SUM;
            back <= S_SUM;
            phase <= 1'b0;
          end
        end
        S_SCAN: begin
          if (idx >= count) begin
            if (cur.kind == KIND_ALLOC) status <= ST_OOM;
            else status <= ST_BADADDR;
            back <= S_SUM;
            state <= S_RD;
          end else if (cur.kind == KIND_ALLOC) begin
            if (r_free && r_pay >= DW'(cur.request_size)) begin
              hit <= idx[AW-1:0];
              granted <= 10'(offset + SW'(HEADER_BYTES));
              if (SW'(r_pay) >= SW'(cur.request_size) + SW'(HEADER_BYTES
                  + MIN_SPLIT_SPARE) && count < CW'(MAX_BLOCKS)) begin
                split_rest <= DW'(SW'(r_pay) - SW'(cur.request_size)
                  - SW'(HEADER_BYTES));
                idx <= count;
                raddr <= AW'(count - CW'(1));
                back <= S_SHIFT;
                state <= S_RD;
              end else begin
                we <= 1'b1;
                waddr <= idx[AW-1:0];
                wdata <= {1'b0, r_pay};
                back <= S_SUM;
                state <= S_RD;
              end
            end else begin
              offset <= offset + SW'(HEADER_BYTES) + SW'(r_pay);
              idx <= idx + CW'(1);
              raddr <= AW'(idx + CW'(1));
              state <= S_RD;
            end
          end else begin
            if (offset + SW'(HEADER_BYTES) == SW'(cur.address)) begin
              we <= 1'b1;
              waddr <= idx[AW-1:0];
              wdata <= {1'b1, r_pay};
              idx <= '0;
              kept <= '0;
              have_acc <= 1'b0;
              raddr <= '0;
              back <= S_MERGE;
              state <= S_DONE;
              phase <= 1'b0;
            end else begin
              offset <= offset + SW'(HEADER_BYTES) + SW'(r_pay);
              idx <= idx + CW'(1);
              raddr <= AW'(idx + CW'(1));
              state <= S_RD;
            end
          end
        end
        // move entry idx-1 to idx, walking down to hit+1
        S_SHIFT: begin
          if (idx > CW'(hit) + CW'(1)) begin
            we <= 1'b1;
            waddr <= idx[AW-1:0];
            wdata <= rdata;
            idx <= idx - CW'(1);
            raddr <= AW'(idx - CW'(2));
            state <= S_RD;
          end else begin
            we <= 1'b1;
            waddr <= AW'(CW'(hit) + CW'(1));
            wdata <= {1'b1, split_rest};
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          we <= 1'b1;
          waddr <= hit;
          wdata <= {1'b0, DW'(cur.request_size)};
          count <= count + CW'(1);
          back <= S_SUM;
          state <= S_RD;
        end
        // compacting merge; acc holds the last kept entry not yet written
        S_MERGE: begin
          if (idx >= count) begin
            we <= 1'b1;
            waddr <= AW'(kept);
            wdata <= {acc_free, acc};
            count <= kept + CW'(1);
            back <= S_SUM;
            state <= S_DONE;
            phase <= 1'b0;
          end else begin
            if (have_acc && acc_free && r_free) begin
              acc <= acc + DW'(HEADER_BYTES) + r_pay;
            end else begin
              if (have_acc) begin
                we <= 1'b1;
                waddr <= AW'(kept);
                wdata <= {acc_free, acc};
                kept <= kept + CW'(1);
              end
              acc <= r_pay;
              acc_free <= r_free;
              have_acc <= 1'b1;
            end
            idx <= idx + CW'(1);
            raddr <= AW'(idx + CW'(1));
            state <= S_RD;
            back <= S_MERGE;
          end
        end
        S_SUM: begin
          if (!phase) begin
            phase <= 1'b1;
          end else if (idx >= count) begin
            rsp_valid <= 1'b1;
            rsp_data.status <= status;
            rsp_data.granted_address <= granted;
            rsp_data.used_bytes <= used[9:0];
            rsp_data.free_bytes <= freeb[9:0];
            state <= S_DONE;
            back <= S_IDLE;
          end else begin
            if (r_free) freeb <= freeb + SW'(r_pay);
            else used <= used + SW'(r_pay);
            idx <= idx + CW'(1);
            raddr <= AW'(idx + CW'(1));
            phase <= 1'b0;
          end
        end
        // wait for a write to land, then continue or wait on the output
        S_DONE: begin
          if (back == S_IDLE) begin
            if (!rsp_valid || rsp.ready) state <= S_IDLE;
          end else if (!phase) begin
            phase <= 1'b1;
            raddr <= '0;
          end else begin
            if (back == S_SUM) begin
              used <= '0;
              freeb <= '0;
              idx <= '0;
              raddr <= '0;
              phase <= 1'b0;
              state <= S_SUM;
            end else begin
              idx <= '0;
              state <= S_RD;
            end
          end
          if (count == '0) count <= CW'(1);
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFA_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count >= CW'(1) && count <= CW'(MAX_BLOCKS))
  `FFA_ASSERT_IMP(a_grant_only_ok, clk, rst, rsp_valid && rsp_data.status != ST_DONE, rsp_data.granted_address == '0)
  `FFA_ASSERT_NXT(a_take_idle, clk, rst, req.valid && req.ready, state == S_RD)
endmodule
